// File: rtl/cube_direction_to_texel_macros.svh
// Assertion macros shared by the cube direction to texel RTL.
`ifndef CUBE_DIRECTION_TO_TEXEL_MACROS_SVH
`define CUBE_DIRECTION_TO_TEXEL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define CDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cdt_pkg.sv
// Package: types and constants of the cube direction to texel block.
`default_nettype none
package cdt_pkg;
   localparam int COMPONENT_BITS = 16;
   localparam int EDGE_BITS      = 12;
   localparam int CSR_BITS       = 13;
   localparam int QUEUE_DEPTH    = 4;
   localparam int PROD_BITS      = EDGE_BITS + COMPONENT_BITS + 1;

   localparam logic [CSR_BITS-1:0] EDGE_RESET = CSR_BITS'(256);

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic signed [COMPONENT_BITS-1:0] dir_x;
      logic signed [COMPONENT_BITS-1:0] dir_y;
      logic signed [COMPONENT_BITS-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [2:0]           face;
      logic [EDGE_BITS-1:0] u_coord;
      logic [EDGE_BITS-1:0] v_coord;
      logic                 invalid;
   } rsp_type;

   // Classified transaction handed from front to back.
   typedef struct packed {
      logic                      invalid;
      logic [2:0]                face;
      logic [COMPONENT_BITS:0]   num_s;
      logic [COMPONENT_BITS:0]   num_t;
      logic [COMPONENT_BITS-1:0] major;
   } work_type;
endpackage
`default_nettype wire

// File: rtl/cube_direction_to_texel.sv
// Top level of the cube direction to texel block.
`default_nettype none
// Maps a signed direction to a cube face (0 +X, 1 -X, 2 +Y, 3 -Y, 4 +Z, 5 -Z)
// and exact integer texel coordinates floor((N-1)*(s+m)/(2m)). One transaction
// per cycle is sustained while neither rsp_stall nor a full queue holds it;
// the front register loads at acceptance, then come one queue slot, one span
// multiply stage and one quotient bit per divider stage.
// The zero vector returns invalid with face and coordinates zero. csr_data sets
// the edge length; write it only while no transaction is in flight.
module cube_direction_to_texel
   import cdt_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CSR_BITS-1:0] csr_data
);
   logic     push, pop, queue_full, queue_not_empty;
   work_type push_data, pop_data;

   assign csr_ready = 1'b1;

   cdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   cdt_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_data)
   );

   cdt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .item_valid (queue_not_empty),
      .item_data  (pop_data),
      .item_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire

// File: rtl/cdt_front.sv
// Front end: accepts directions, picks the face and forms the numerators.
`default_nettype none
module cdt_front
   import cdt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   output logic          push,
   output work_type      push_data,
   input  wire logic     queue_full
);
   logic     valid_ff, valid_in;
   work_type work_ff, work_in;
   logic     advance;

   logic [COMPONENT_BITS-1:0] ax, ay, az, m;
   logic signed [COMPONENT_BITS:0] sx, sy, sz, s, t;
   logic [2:0] face;
   logic       zero;

   always_comb begin
      sx = {req_data.dir_x[COMPONENT_BITS-1], req_data.dir_x};
      sy = {req_data.dir_y[COMPONENT_BITS-1], req_data.dir_y};
      sz = {req_data.dir_z[COMPONENT_BITS-1], req_data.dir_z};
      ax = req_data.dir_x[COMPONENT_BITS-1] ? COMPONENT_BITS'(-sx) : req_data.dir_x;
      ay = req_data.dir_y[COMPONENT_BITS-1] ? COMPONENT_BITS'(-sy) : req_data.dir_y;
      az = req_data.dir_z[COMPONENT_BITS-1] ? COMPONENT_BITS'(-sz) : req_data.dir_z;
      zero = (ax == '0) && (ay == '0) && (az == '0);
      if (ax >= ay && ax >= az) begin
         m = ax;
         t = -sy;
         if (!req_data.dir_x[COMPONENT_BITS-1]) begin
            face = FACE_POS_X;
            s    = -sz;
         end else begin
            face = FACE_NEG_X;
            s    = sz;
         end
      end else if (ay >= az) begin
         m = ay;
         s = sx;
         if (!req_data.dir_y[COMPONENT_BITS-1]) begin
            face = FACE_POS_Y;
            t    = sz;
         end else begin
            face = FACE_NEG_Y;
            t    = -sz;
         end
      end else begin
         m = az;
         t = -sy;
         if (!req_data.dir_z[COMPONENT_BITS-1]) begin
            face = FACE_POS_Z;
            s    = sx;
         end else begin
            face = FACE_NEG_Z;
            s    = -sx;
         end
      end
      work_in.invalid = zero;
      work_in.face    = zero ? FACE_POS_X : face;
      work_in.num_s   = (COMPONENT_BITS+1)'(s + $signed({1'b0, m}));
      work_in.num_t   = (COMPONENT_BITS+1)'(t + $signed({1'b0, m}));
      work_in.major   = m;
   end

   assign advance   = !valid_ff || !queue_full;
   assign req_stall = !advance;
   assign push      = valid_ff && !queue_full;
   assign push_data = work_ff;
   assign valid_in  = advance ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         work_ff <= work_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/cdt_queue.sv
// Short queue between the front and back ends.
`default_nettype none
module cdt_queue
   import cdt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output work_type      pop_data
);
   `include "cube_direction_to_texel_macros.svh"

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   work_type mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `CDT_ASSERT_NOW(a_no_push_full, clock, reset, push, !full, "push into full queue")
   `CDT_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, not_empty, "pop from empty queue")
   `CDT_ASSERT_NEXT(a_count_up, clock, reset, push && !pop,
      count_ff == $past(count_ff) + 1'b1, "queue count lost a push")
endmodule
`default_nettype wire

// File: rtl/cdt_back.sv
// Back end: edge register, span multiply and pipelined restoring division.
`default_nettype none
module cdt_back
   import cdt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [CSR_BITS-1:0] csr_data,
   input  wire logic                item_valid,
   input  wire work_type            item_data,
   output logic                     item_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data
);
   `include "cube_direction_to_texel_macros.svh"

   localparam int PW = PROD_BITS;
   localparam int DW = COMPONENT_BITS + 1;
   localparam logic [CSR_BITS:0] EDGE_MAX = (CSR_BITS+1)'(1 << EDGE_BITS);

   logic [CSR_BITS-1:0]  edge_ff;
   logic [CSR_BITS:0]    n_eff;
   logic [EDGE_BITS-1:0] span;
   logic                 adv;

   logic                 valid_ff   [EDGE_BITS+1];
   logic                 invalid_ff [EDGE_BITS+1];
   logic [2:0]           face_ff    [EDGE_BITS+1];
   logic [DW-1:0]        den_ff     [EDGE_BITS+1];
   logic [PW-1:0]        rem_u_ff   [EDGE_BITS+1];
   logic [PW-1:0]        rem_v_ff   [EDGE_BITS+1];
   logic [EDGE_BITS-1:0] q_u_ff     [EDGE_BITS+1];
   logic [EDGE_BITS-1:0] q_v_ff     [EDGE_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= EDGE_RESET;
      end else if (csr_valid) begin
         edge_ff <= csr_data;
      end
   end

   always_comb begin
      n_eff = {1'b0, edge_ff};
      if (edge_ff == '0) begin
         n_eff = (CSR_BITS+1)'(1);
      end else if (n_eff > EDGE_MAX) begin
         n_eff = EDGE_MAX;
      end
      span = EDGE_BITS'(n_eff - 1'b1);
   end

   assign adv      = !valid_ff[EDGE_BITS] || !rsp_stall;
   assign item_pop = adv && item_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         invalid_ff[0] <= item_data.invalid;
         face_ff[0]    <= item_data.face;
         den_ff[0]     <= {item_data.major, 1'b0};
         rem_u_ff[0]   <= PW'(span) * PW'(item_data.num_s);
         rem_v_ff[0]   <= PW'(span) * PW'(item_data.num_t);
         q_u_ff[0]     <= '0;
         q_v_ff[0]     <= '0;
      end
   end

   for (genvar j = 1; j <= EDGE_BITS; j++) begin : g_div
      localparam int B = EDGE_BITS - j;
      logic [PW-1:0] trial;
      logic          take_u, take_v;

      assign trial  = PW'(den_ff[j-1]) << B;
      assign take_u = rem_u_ff[j-1] >= trial;
      assign take_v = rem_v_ff[j-1] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            invalid_ff[j] <= invalid_ff[j-1];
            face_ff[j]    <= face_ff[j-1];
            den_ff[j]     <= den_ff[j-1];
            rem_u_ff[j]   <= take_u ? rem_u_ff[j-1] - trial : rem_u_ff[j-1];
            rem_v_ff[j]   <= take_v ? rem_v_ff[j-1] - trial : rem_v_ff[j-1];
            q_u_ff[j]     <= q_u_ff[j-1] | (EDGE_BITS'(take_u) << B);
            q_v_ff[j]     <= q_v_ff[j-1] | (EDGE_BITS'(take_v) << B);
         end
      end
   end

   assign rsp_valid        = valid_ff[EDGE_BITS];
   assign rsp_data.invalid = invalid_ff[EDGE_BITS];
   assign rsp_data.face    = face_ff[EDGE_BITS];
   assign rsp_data.u_coord = invalid_ff[EDGE_BITS] ? '0 : q_u_ff[EDGE_BITS];
   assign rsp_data.v_coord = invalid_ff[EDGE_BITS] ? '0 : q_v_ff[EDGE_BITS];

   `CDT_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && rsp_data.invalid,
      rsp_data.face == FACE_POS_X, "invalid transaction with nonzero face")
   `CDT_ASSERT_NOW(a_u_in_range, clock, reset, rsp_valid,
      rsp_data.u_coord <= span && rsp_data.v_coord <= span, "texel beyond face edge")
   `CDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled transaction changed")
endmodule
`default_nettype wire
